// File: rtl/core/dmcf_pkg.sv
// Shared types and constants for the dual-mode command framer.
// Holds the character codes, field widths, the controller state type and the
// command and status structs that pass between controller and datapath.
package dmcf_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 5;

    localparam logic [BYTE_W-1:0] CHAR_OPEN  = 8'h5B;  // '['
    localparam logic [BYTE_W-1:0] CHAR_CLOSE = 8'h5D;  // ']'
    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD,
        ST_OUT,
        ST_EMPTY
    } t_dmcf_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;     // an input transaction completes this cycle
        logic rd_en;      // read the packet store at the current read index
        logic advance;    // step the read index to the next stored byte
        logic empty_sel;  // the result on offer is the empty bracket marker
    } t_dmcf_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic emit_go;     // the byte on offer completes a packet
        logic emit_empty;  // and that packet is an empty bracket packet
        logic last;        // the read index points at the final stored byte
    } t_dmcf_status;

endpackage

// File: rtl/core/dmcf_rx_if.sv
// Receive channel of the command framer: one received byte per transaction.
// Depends on dmcf_pkg for the byte width.
interface dmcf_rx_if import dmcf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: rtl/core/dmcf_cmd_if.sv
// Result channel of the command framer: one command byte per transaction.
// Depends on dmcf_pkg for the field widths.
interface dmcf_cmd_if import dmcf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic [LEN_W-1:0]  packet_length;
    logic              is_last;
    logic              is_empty;
    logic              framed_by_brackets;

    modport source (output valid, output data_byte, output packet_length,
                    output is_last, output is_empty, output framed_by_brackets,
                    input ready);
    modport sink   (input valid, input data_byte, input packet_length,
                    input is_last, input is_empty, input framed_by_brackets,
                    output ready);
endinterface

// File: rtl/core/dmcf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module dmcf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 31,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/dmcf_ctrl.sv
// Controller state machine of the command framer.
// Depends on dmcf_pkg for the state type and the command and status structs.
module dmcf_ctrl import dmcf_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  logic         i_out_ready,
    input  t_dmcf_status i_status,
    output t_dmcf_cmd    o_cmd,
    output logic         o_in_ready,
    output logic         o_out_valid
);

    t_dmcf_state r_state;
    t_dmcf_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_status.emit_go) begin
                    n_state = i_status.emit_empty ? ST_EMPTY : ST_RD;
                end
            end
            ST_RD: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_out_ready) begin
                    n_state = i_status.last ? ST_IDLE : ST_RD;
                end
            end
            ST_EMPTY: begin
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            ST_RD: begin
                o_cmd.rd_en = 1'b1;
            end
            ST_OUT: begin
                o_out_valid   = 1'b1;
                o_cmd.advance = i_out_ready && !i_status.last;
            end
            ST_EMPTY: begin
                o_out_valid     = 1'b1;
                o_cmd.empty_sel = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // A read is always followed by its presentation cycle.
    a_rd_then_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RD) |=> (r_state == ST_OUT))
        else $error("read cycle not followed by output cycle");

    // An empty bracket packet goes straight to its single marker result.
    a_empty_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.accept && i_status.emit_go && i_status.emit_empty)
        |=> (r_state == ST_EMPTY))
        else $error("empty packet did not select the marker result");

    // A stalled result stays on offer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && !i_out_ready) |=> (r_state == ST_OUT))
        else $error("stalled result withdrawn");

endmodule

// File: rtl/core/dmcf_dp.sv
// Datapath of the command framer: byte decode, framing state, packet store
// and result fields. Depends on dmcf_pkg and dmcf_ram.
module dmcf_dp import dmcf_pkg::*; #(
    parameter int PACKET_SIZE = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dmcf_cmd         i_cmd,
    input  logic [BYTE_W-1:0] i_rx_byte,
    output t_dmcf_status      o_status,
    output logic [BYTE_W-1:0] o_data_byte,
    output logic [LEN_W-1:0]  o_packet_length,
    output logic              o_is_last,
    output logic              o_is_empty,
    output logic              o_framed_by_brackets
);

    localparam int CAPACITY = PACKET_SIZE - 1;
    localparam int CW       = $clog2(PACKET_SIZE);
    localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [CW-1:0] FILL_FULL = CW'(CAPACITY);

    logic          r_mode;
    logic          n_mode;
    logic [CW-1:0] r_fill;
    logic [CW-1:0] n_fill;
    logic [CW-1:0] r_len;
    logic          r_framed;
    logic [AW-1:0] r_idx;

    logic is_open;
    logic is_close;
    logic is_term;
    logic is_data;
    logic full;
    logic emit_go;
    logic wr_en;
    logic [BYTE_W-1:0] rd_data;
    logic [CW+LEN_W-1:0] len_ext;

    assign is_open  = (i_rx_byte == CHAR_OPEN);
    assign is_close = r_mode && (i_rx_byte == CHAR_CLOSE);
    assign is_term  = !r_mode && ((i_rx_byte == CHAR_CR) || (i_rx_byte == CHAR_LF));
    assign is_data  = !is_open && !is_close && !is_term;
    assign full     = (r_fill == FILL_FULL);
    assign emit_go  = !is_open && (is_close || (is_term && (r_fill != '0)));
    assign wr_en    = i_cmd.accept && is_data && !full;

    assign o_status.emit_go    = emit_go;
    assign o_status.emit_empty = (r_fill == '0);
    assign o_status.last       = ((CW'(r_idx) + CW'(1)) == r_len);

    always_comb begin
        n_mode = r_mode;
        n_fill = r_fill;
        if (i_cmd.accept) begin
            if (is_open) begin
                n_mode = 1'b1;
                n_fill = '0;
            end else if (is_close) begin
                n_mode = 1'b0;
                n_fill = '0;
            end else if (is_term) begin
                n_fill = '0;
            end else if (full) begin
                // Overflow drops the byte; bracket form falls back to line form.
                n_mode = 1'b0;
                n_fill = '0;
            end else begin
                n_fill = r_fill + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_fill <= '0;
            r_idx  <= '0;
        end else begin
            r_mode <= n_mode;
            r_fill <= n_fill;
            if (i_cmd.accept && emit_go) begin
                r_idx <= '0;
            end else if (i_cmd.advance) begin
                r_idx <= r_idx + AW'(1);
            end
        end
    end

    // Snapshot of the completed packet, held while its bytes go out.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && emit_go) begin
            r_len    <= r_fill;
            r_framed <= is_close;
        end
    end

    dmcf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_fill[AW-1:0]),
        .i_wdata (i_rx_byte),
        .i_re    (i_cmd.rd_en),
        .i_raddr (r_idx),
        .o_rdata (rd_data)
    );

    assign len_ext              = (CW+LEN_W)'(r_len);
    assign o_data_byte          = i_cmd.empty_sel ? '0 : rd_data;
    assign o_packet_length      = len_ext[LEN_W-1:0];
    assign o_is_last            = i_cmd.empty_sel || o_status.last;
    assign o_is_empty           = i_cmd.empty_sel;
    assign o_framed_by_brackets = r_framed;

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_FULL)
        else $error("fill count beyond store capacity");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.accept |=> ($stable(r_fill) && $stable(r_mode)))
        else $error("framing state changed without an input transaction");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_en |-> (CW'(r_idx) < r_len))
        else $error("store read beyond the completed packet");

endmodule

// File: rtl/core/dual_mode_command_framer_top.sv
// Top level of the dual-mode command framer.
// Depends on dmcf_pkg, dmcf_rx_if, dmcf_cmd_if, dmcf_ctrl and dmcf_dp.

// The framer takes one received byte per input transaction and collects
// command bytes into a packet store of PACKET_SIZE-1 bytes. In bracket form,
// '[' starts or restarts a packet and ']' completes it, even when it is empty;
// in line form, CR or LF completes a packet that holds at least one byte, and
// a ']' seen in line form is ordinary data. A byte that arrives with the store
// full is dropped: in bracket form the packet is abandoned and the framer goes
// back to line form, in line form the packet simply starts again. A completed
// packet leaves as a run of result transactions, one per byte in arrival
// order, with is_last on the final one; an empty bracket packet gives a single
// transaction with is_empty set and a zero data byte. Each byte of a
// completed packet is first read through the packet store's registered port
// and then held on offer until it is taken. No input transaction is taken
// while a packet is being emitted, and output back-pressure stretches the
// run. The store needs no clearing after reset: only bytes written for the
// current packet are ever read.
module dual_mode_command_framer_top import dmcf_pkg::*; #(
    parameter int PACKET_SIZE = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dmcf_rx_if.sink     i_rx_if,
    dmcf_cmd_if.source  o_cmd_if
);

    t_dmcf_cmd    cmd;
    t_dmcf_status status;

    // Sequencing: accept bytes, then walk the store for a completed packet.
    dmcf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_rx_if.valid),
        .i_out_ready (o_cmd_if.ready),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_ready  (i_rx_if.ready),
        .o_out_valid (o_cmd_if.valid)
    );

    // Decode, framing state, packet store and result fields.
    dmcf_dp #(
        .PACKET_SIZE (PACKET_SIZE)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .i_rx_byte            (i_rx_if.rx_byte),
        .o_status             (status),
        .o_data_byte          (o_cmd_if.data_byte),
        .o_packet_length      (o_cmd_if.packet_length),
        .o_is_last            (o_cmd_if.is_last),
        .o_is_empty           (o_cmd_if.is_empty),
        .o_framed_by_brackets (o_cmd_if.framed_by_brackets)
    );

endmodule

// File: tb/tb_dual_mode_command_framer_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for dual_mode_command_framer_top: a directed table of received bytes,
// then random framed packets, with every command transaction checked against a local model.
// Depends on dmcf_pkg, dmcf_rx_if, dmcf_cmd_if and the framer RTL.
module tb_dual_mode_command_framer_top import dmcf_pkg::*; ();

    localparam int PACKET_SIZE  = 32;
    localparam int STORE_DEPTH  = PACKET_SIZE - 1;
    localparam int RANDOM_ITEMS = 400;
    // A full packet needs a store read and an offer for each of its bytes, so the
    // drain wait comfortably covers anything still in flight at the end.
    localparam int DRAIN_CYCLES = 4 * STORE_DEPTH;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int REPORT_MAX   = 10;

    // One command transaction as it appears on the result channel.
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  packet_length;
        logic              is_last;
        logic              is_empty;
        logic              framed_by_brackets;
    } t_cmd_beat;

    // One received byte to offer. When fixed is set, the row carries the single
    // command transaction it must produce, written out by hand.
    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              fixed;
        t_cmd_beat         beat;
    } t_rx_row;

    typedef enum int {
        SEQ_BRACKET,
        SEQ_LINE,
        SEQ_BRACKET_OVF,
        SEQ_LINE_OVF,
        SEQ_NOISE
    } t_seq_kind;

    localparam t_cmd_beat NO_BEAT    = '0;
    localparam t_cmd_beat EMPTY_BEAT = '{8'h00, 5'd0, 1'b1, 1'b1, 1'b1};

    // The directed part. Rows whose outcome is obvious carry it; the others
    // (multi-byte packets, restarts) are left to the model.
    localparam t_rx_row DIRECTED [24] = '{
        '{CHAR_LF,    1'b0, NO_BEAT},                            // empty line: nothing
        '{CHAR_CR,    1'b0, NO_BEAT},
        '{CHAR_OPEN,  1'b0, NO_BEAT},
        '{CHAR_CLOSE, 1'b1, EMPTY_BEAT},                         // "[]"
        '{CHAR_CLOSE, 1'b0, NO_BEAT},                            // stray close is data
        '{CHAR_CR,    1'b1, '{CHAR_CLOSE, 5'd1, 1'b1, 1'b0, 1'b0}},
        '{8'h00,      1'b0, NO_BEAT},
        '{CHAR_LF,    1'b1, '{8'h00, 5'd1, 1'b1, 1'b0, 1'b0}},
        '{8'hFF,      1'b0, NO_BEAT},
        '{CHAR_LF,    1'b1, '{8'hFF, 5'd1, 1'b1, 1'b0, 1'b0}},
        '{CHAR_OPEN,  1'b0, NO_BEAT},
        '{8'h41,      1'b0, NO_BEAT},
        '{CHAR_OPEN,  1'b0, NO_BEAT},                            // restart drops the 'A'
        '{CHAR_CR,    1'b0, NO_BEAT},                            // CR and LF are data here
        '{CHAR_LF,    1'b0, NO_BEAT},
        '{8'h80,      1'b0, NO_BEAT},
        '{CHAR_CLOSE, 1'b0, NO_BEAT},
        '{8'h78,      1'b0, NO_BEAT},
        '{CHAR_OPEN,  1'b0, NO_BEAT},                            // open from line form
        '{CHAR_CLOSE, 1'b1, EMPTY_BEAT},
        '{8'h71,      1'b0, NO_BEAT},
        '{CHAR_CLOSE, 1'b0, NO_BEAT},
        '{CHAR_CR,    1'b0, NO_BEAT},
        '{CHAR_LF,    1'b0, NO_BEAT}                             // terminator after a packet
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    dmcf_rx_if  rx_if ();
    dmcf_cmd_if cmd_if ();

    dual_mode_command_framer_top #(
        .PACKET_SIZE (PACKET_SIZE)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rx_if  (rx_if),
        .o_cmd_if (cmd_if)
    );

    // Local copy of the framer's state.
    bit                bracket_form;
    int unsigned       fill;
    logic [BYTE_W-1:0] held_bytes [STORE_DEPTH];

    t_rx_row     byte_feed [$];      // bytes still to be offered
    t_cmd_beat   predicted_run [$];  // transactions caused by the latest byte
    t_cmd_beat   awaited_beats [$];  // transactions the framer still owes us
    t_rx_row     on_offer;
    bit          rx_fire;
    bit          hold_off;
    wire         steady;
    int unsigned rx_taken;
    int unsigned mismatches;
    int unsigned cycles;

    // A stretch of the run in which neither side idles.
    assign steady = (rx_taken >= 250) && (rx_taken < 350);

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Model of the framer
    // ------------------------------------------------------------------

    // A data byte goes into the store; with the store full it is dropped, the
    // count restarts and any bracket packet is abandoned.
    function automatic void store_data(logic [BYTE_W-1:0] b);
        if (fill < STORE_DEPTH) begin
            held_bytes[fill] = b;
            fill++;
        end else begin
            fill         = 0;
            bracket_form = 1'b0;
        end
    endfunction

    // Turns the stored packet into its run of command transactions.
    function automatic void emit_run(logic brk);
        t_cmd_beat beat;
        if (fill == 0) begin
            beat                    = EMPTY_BEAT;
            beat.framed_by_brackets = brk;
            predicted_run.push_back(beat);
        end else begin
            for (int k = 0; k < fill; k++) begin
                beat.data_byte          = held_bytes[k];
                beat.packet_length      = fill[LEN_W-1:0];
                beat.is_last            = (k + 1 == fill);
                beat.is_empty           = 1'b0;
                beat.framed_by_brackets = brk;
                predicted_run.push_back(beat);
            end
        end
    endfunction

    function automatic void frame_rx_byte(logic [BYTE_W-1:0] b);
        predicted_run.delete();
        if (b == CHAR_OPEN) begin
            bracket_form = 1'b1;
            fill         = 0;
        end else if (bracket_form) begin
            if (b == CHAR_CLOSE) begin
                emit_run(1'b1);
                bracket_form = 1'b0;
                fill         = 0;
            end else begin
                store_data(b);
            end
        end else if (b == CHAR_CR || b == CHAR_LF) begin
            if (fill > 0) begin
                emit_run(1'b0);
                fill = 0;
            end
        end else begin
            store_data(b);
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------

    function automatic void feed(logic [BYTE_W-1:0] b);
        byte_feed.push_back(t_rx_row'{b, 1'b0, NO_BEAT});
    endfunction

    // A random payload byte that cannot end or restart the packet it sits in.
    function automatic logic [BYTE_W-1:0] pick_data(bit line_form);
        logic [BYTE_W-1:0] b;
        do
            b = BYTE_W'($urandom_range(0, 255));
        while (b == CHAR_OPEN || (!line_form && b == CHAR_CLOSE) ||
               (line_form && (b == CHAR_CR || b == CHAR_LF)));
        return b;
    endfunction

    // Mostly short packets, now and then a long one up to a full store.
    function automatic int unsigned pick_size(int unsigned lo);
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(lo, 6);
        return $urandom_range(7, STORE_DEPTH);
    endfunction

    task automatic queue_sequence(t_seq_kind kind, int unsigned n);
        case (kind)
            SEQ_BRACKET: begin
                feed(CHAR_OPEN);
                repeat (n) feed(pick_data(1'b0));
                feed(CHAR_CLOSE);
            end
            SEQ_LINE: begin
                repeat (n) feed(pick_data(1'b1));
                feed($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
            end
            // The store fills, the next byte is dropped and the framer falls
            // back to line form, so the n-1 bytes after it start a line packet.
            SEQ_BRACKET_OVF: begin
                feed(CHAR_OPEN);
                repeat (STORE_DEPTH + n) feed(pick_data(1'b0));
            end
            SEQ_LINE_OVF: begin
                repeat (STORE_DEPTH + n) feed(pick_data(1'b1));
                feed(CHAR_LF);
            end
            default: begin
                repeat (n) begin
                    case ($urandom_range(0, 4))
                        0:       feed(CHAR_OPEN);
                        1:       feed(CHAR_CLOSE);
                        2:       feed(CHAR_CR);
                        3:       feed(CHAR_LF);
                        default: feed(BYTE_W'($urandom_range(0, 255)));
                    endcase
                end
            end
        endcase
    endtask

    task automatic queue_random_traffic();
        int unsigned start;
        int unsigned roll;
        start = byte_feed.size();
        // Full-length packets and both kinds of overflow are always present.
        queue_sequence(SEQ_BRACKET, STORE_DEPTH);
        queue_sequence(SEQ_LINE, STORE_DEPTH);
        queue_sequence(SEQ_BRACKET_OVF, 1);
        queue_sequence(SEQ_LINE_OVF, 2);
        while (byte_feed.size() - start < RANDOM_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < 42)
                queue_sequence(SEQ_BRACKET, pick_size(0));
            else if (roll < 80)
                queue_sequence(SEQ_LINE, pick_size(1));
            else if (roll < 83)
                queue_sequence(SEQ_BRACKET_OVF, $urandom_range(1, 3));
            else if (roll < 86)
                queue_sequence(SEQ_LINE_OVF, $urandom_range(1, 3));
            else
                queue_sequence(SEQ_NOISE, $urandom_range(1, 6));
        end
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    // Compares one command transaction with the oldest one awaited. A
    // transaction that arrives with nothing awaited is a failure as well.
    function automatic void check_beat(t_cmd_beat got);
        t_cmd_beat want;
        bit        bad;
        want = NO_BEAT;
        bad  = 1'b1;
        if (awaited_beats.size() != 0) begin
            want = awaited_beats.pop_front();
            bad  = (got.data_byte          !== want.data_byte) ||
                   (got.packet_length      !== want.packet_length) ||
                   (got.is_last            !== want.is_last) ||
                   (got.is_empty           !== want.is_empty) ||
                   (got.framed_by_brackets !== want.framed_by_brackets);
        end
        if (bad) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
                $display("cycle %0d: command mismatch%s: expected byte %h len %0d %s",
                         cycles, (awaited_beats.size() == 0 && want == NO_BEAT) ?
                         " (none awaited)" : "",
                         want.data_byte, want.packet_length, "");
                $display("    expected last %b empty %b brackets %b",
                         want.is_last, want.is_empty, want.framed_by_brackets);
                $display("    got byte %h len %0d last %b empty %b brackets %b",
                         got.data_byte, got.packet_length, got.is_last,
                         got.is_empty, got.framed_by_brackets);
            end
        end
    endfunction

    // Both channels are sampled at the rising edge. An accepted byte moves the
    // model on; rows with a hand-written outcome await that outcome instead of
    // the model's, so the model's state still follows every byte.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            rx_fire = rx_if.valid && rx_if.ready;
            if (rx_fire) begin
                rx_taken++;
                frame_rx_byte(on_offer.rx_byte);
                if (on_offer.fixed)
                    awaited_beats.push_back(on_offer.beat);
                else
                    foreach (predicted_run[i]) awaited_beats.push_back(predicted_run[i]);
            end
            if (cmd_if.valid && cmd_if.ready)
                check_beat(t_cmd_beat'{cmd_if.data_byte, cmd_if.packet_length,
                                       cmd_if.is_last, cmd_if.is_empty,
                                       cmd_if.framed_by_brackets});
        end
    end

    // The run is abandoned if it has not finished after a generous number of
    // cycles; a correct run needs a small fraction of this.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_dual_mode_command_framer_top: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driving, on the falling edge
    // ------------------------------------------------------------------

    // The sender holds a byte on offer until it is taken, and only idles
    // between transactions.
    always @(negedge i_clk) begin
        if (i_rst_n && (!rx_if.valid || rx_fire)) begin
            if (byte_feed.size() != 0 && (steady || $urandom_range(0, 99) >= 15)) begin
                on_offer      = byte_feed.pop_front();
                rx_if.valid   = 1'b1;
                rx_if.rx_byte = on_offer.rx_byte;
            end else begin
                rx_if.valid = 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        cmd_if.ready = !hold_off && (steady || $urandom_range(0, 99) >= 15);
    end

    // Once, part way through, the receiver refuses everything for a long
    // stretch while the sender keeps offering bytes, so the framer has to
    // stall its input behind a packet it cannot emit.
    initial begin
        hold_off = 1'b0;
        wait (rx_taken >= 120);
        @(posedge i_clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off = 1'b0;
    end

    initial begin
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        cmd_if.ready  = 1'b0;
        bracket_form  = 1'b0;
        fill          = 0;
        foreach (DIRECTED[i]) byte_feed.push_back(DIRECTED[i]);
        queue_random_traffic();

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Wait for every byte to be taken and every transaction to arrive, then
        // give the framer time to show anything it should not have sent.
        while (byte_feed.size() != 0 || rx_if.valid || awaited_beats.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && awaited_beats.size() == 0)
            $display("tb_dual_mode_command_framer_top: PASS");
        else
            $display("tb_dual_mode_command_framer_top: FAIL");
        $finish;
    end

endmodule

// File: dual_mode_command_framer_top.f
rtl/core/dmcf_pkg.sv
rtl/core/dmcf_rx_if.sv
rtl/core/dmcf_cmd_if.sv
rtl/core/dmcf_ram.sv
rtl/core/dmcf_ctrl.sv
rtl/core/dmcf_dp.sv
rtl/core/dual_mode_command_framer_top.sv
tb/tb_dual_mode_command_framer_top.sv
